// ===== rtl/core/umbfr_pkg.sv =====
// Package with shared types, constants and the CRC byte update for the UMB frame receiver.
package umbfr_pkg;

  localparam logic [7:0]  SOH_BYTE    = 8'h01;
  localparam logic [8:0]  FRAME_EXTRA = 9'd12;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    RK_PAYLOAD   = 2'd0,
    RK_DONE      = 2'd1,
    RK_TO_HUNT   = 2'd2,
    RK_TO_FRAME  = 2'd3
  } result_kind_t;

  typedef enum logic {
    PH_HUNT  = 1'b0,
    PH_FRAME = 1'b1
  } phase_t;

  // One result item as it sits in the queue.
  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   payload_byte;
    logic [7:0]   prot_version;
    logic [7:0]   to_id;
    logic [3:0]   to_class;
    logic [7:0]   from_id;
    logic [3:0]   from_class;
    logic [7:0]   cmd_id;
    logic [7:0]   body_length;
    logic [15:0]  crc_received;
    logic         crc_ok;
    logic [8:0]   frame_bytes;
  } result_t;

  // Reflected CRC-16 update over one byte, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/umbfr_parser.sv =====
// Front end: frame parser, CRC, tick counting and result generation.
module umbfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [7:0]          in_byte,
  input  logic                q_room,
  output logic                res_valid,
  output umbfr_pkg::result_t  res
);

  umbfr_pkg::phase_t phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [8:0]  total_r, total_nxt;
  logic [7:0]  hdr_r [7];
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_hi_r;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] limit_r;
  logic        hdr_we;
  logic [2:0]  hdr_idx;
  logic        lo_we, hi_we;
  logic [15:0] tick_inc;
  logic [15:0] crc_upd;
  logic [8:0]  pos3, pos2;
  logic [8:0]  pay_end;
  logic        fire;

  assign in_ready = q_room;
  assign fire     = in_valid && in_ready;
  assign tick_inc = (in_kind && tick_r != umbfr_pkg::TICK_MAX) ? tick_r + 16'd1 : tick_r;
  assign crc_upd  = umbfr_pkg::crc_byte(crc_r, in_byte);
  assign pos3     = pos_r + 9'd3;
  assign pos2     = pos_r + 9'd2;
  assign pay_end  = 9'd8 + {1'b0, hdr_r[5]};

  // Decode one transfer into next state and an optional result.
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    crc_nxt   = crc_r;
    tick_nxt  = tick_inc;
    hdr_we    = 1'b0;
    hdr_idx   = 3'd0;
    lo_we     = 1'b0;
    hi_we     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (tick_inc > limit_r) begin
      res_valid = 1'b1;
      res.kind  = (phase_r == umbfr_pkg::PH_HUNT) ? umbfr_pkg::RK_TO_HUNT
                                                   : umbfr_pkg::RK_TO_FRAME;
      phase_nxt = umbfr_pkg::PH_HUNT;
      pos_nxt   = '0;
      total_nxt = '0;
      crc_nxt   = umbfr_pkg::CRC_INIT;
      tick_nxt  = '0;
    end else if (!in_kind) begin
      if (phase_r == umbfr_pkg::PH_HUNT) begin
        if (in_byte == umbfr_pkg::SOH_BYTE) begin
          phase_nxt = umbfr_pkg::PH_FRAME;
          crc_nxt   = umbfr_pkg::crc_byte(umbfr_pkg::CRC_INIT, in_byte);
          pos_nxt   = 9'd1;
        end
      end else begin
        pos_nxt = pos_r + 9'd1;
        if (pos_r >= 9'd1 && pos_r <= 9'd6) begin
          hdr_we  = 1'b1;
          hdr_idx = 3'(pos_r - 9'd1);
          crc_nxt = crc_upd;
          if (pos_r == 9'd6) total_nxt = {1'b0, in_byte} + umbfr_pkg::FRAME_EXTRA;
        end else begin
          if (pos_r == 9'd8) begin
            hdr_we  = 1'b1;
            hdr_idx = 3'd6;
          end
          if (pos3 < total_r) begin
            crc_nxt = crc_upd;
            if (pos_r >= 9'd10 && pos_r < pay_end) begin
              res_valid        = 1'b1;
              res.kind         = umbfr_pkg::RK_PAYLOAD;
              res.payload_byte = in_byte;
            end
          end else if (pos3 == total_r) begin
            lo_we = 1'b1;
          end else if (pos2 == total_r) begin
            hi_we = 1'b1;
          end else begin
            res_valid        = 1'b1;
            res.kind         = umbfr_pkg::RK_DONE;
            res.prot_version = hdr_r[0];
            res.to_id        = hdr_r[1];
            res.to_class     = hdr_r[2][7:4];
            res.from_id      = hdr_r[3];
            res.from_class   = hdr_r[4][7:4];
            res.cmd_id       = hdr_r[6];
            res.body_length  = hdr_r[5];
            res.crc_received = {crc_hi_r, crc_lo_r};
            res.crc_ok       = ({crc_hi_r, crc_lo_r} == crc_r);
            res.frame_bytes  = total_r;
            phase_nxt = umbfr_pkg::PH_HUNT;
            pos_nxt   = '0;
            total_nxt = '0;
            crc_nxt   = umbfr_pkg::CRC_INIT;
            tick_nxt  = '0;
          end
        end
      end
    end
  end

  // Advance parser state on each accepted transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= umbfr_pkg::PH_HUNT;
      pos_r    <= '0;
      total_r  <= '0;
      crc_r    <= umbfr_pkg::CRC_INIT;
      tick_r   <= '0;
      limit_r  <= 16'd5;
      crc_lo_r <= '0;
      crc_hi_r <= '0;
      for (int i = 0; i < 7; i++) hdr_r[i] <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        total_r <= total_nxt;
        crc_r   <= crc_nxt;
        tick_r  <= tick_nxt;
        if (hdr_we) hdr_r[hdr_idx] <= in_byte;
        if (lo_we) crc_lo_r <= in_byte;
        if (hi_we) crc_hi_r <= in_byte;
        if (phase_nxt == umbfr_pkg::PH_HUNT && phase_r == umbfr_pkg::PH_FRAME) begin
          for (int i = 0; i < 7; i++) hdr_r[i] <= '0;
          crc_lo_r <= '0;
          crc_hi_r <= '0;
        end
      end
    end
  end

  // A frame never outgrows its declared total.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == umbfr_pkg::PH_FRAME && pos_r > 9'd7) |-> pos_r < total_r)
    else $error("byte position past frame end");
  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == umbfr_pkg::PH_HUNT) |-> (pos_r == 9'd0 && crc_r == umbfr_pkg::CRC_INIT))
    else $error("hunt state not cleared");
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && (res.kind == umbfr_pkg::RK_TO_HUNT ||
     res.kind == umbfr_pkg::RK_TO_FRAME)) |=> tick_r == 16'd0)
    else $error("tick count not cleared after timeout");

endmodule

// ===== rtl/core/umbfr_queue.sv =====
// Back end: small result queue; out_data is read directly from its storage array.
module umbfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  umbfr_pkg::result_t wr_data,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output umbfr_pkg::result_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  umbfr_pkg::result_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          rd_en;

  assign room      = (cnt_r != (AW+1)'(DEPTH)) || out_ready;
  assign out_valid = (cnt_r != '0);
  assign rd_en     = out_valid && out_ready;
  assign out_data  = mem_r[rp_r];

  // Push and pop the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

endmodule

// ===== rtl/core/umb_frame_receiver.sv =====
// Top level of the UMB binary frame receiver.
// Input stream in_*: one transfer is either a received byte (tuser 0, byte in
// tdata) or a one-second tick (tuser 1). Bytes are discarded until SOH, then
// a frame of L+12 bytes is parsed and checked with a reflected CRC-16.
// Output stream out_*: payload bytes as they arrive, a frame summary on the
// final byte, or a timeout report when the tick count passes cfg limit.
// Throughput: one input transfer per cycle while in_tready is high; the CRC
// byte update is combinational inside the parser. Results are registered in
// the queue and reach out_* once older results have drained.
// A queue of DEPTH results decouples the parser from the receiver; when the
// receiver stalls and the queue fills, in_tready drops until an entry drains.
// Reset (rst_n low, synchronous) empties the queue, restarts the hunt and sets
// the timeout limit to 5. cfg_we writes the limit; write it only while no
// transfer is in flight.
module umb_frame_receiver #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic         in_tuser,   // [0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // payload_byte, prot_version, to_id, to_class, from_id,
                                   // from_class, cmd_id, body_length, crc_received,
                                   // crc_ok, frame_bytes, zero fill
  output logic [1:0]   out_tuser   // [1:0] result_kind
);

  logic               res_valid, q_room;
  umbfr_pkg::result_t res, q_out;

  umbfr_parser u_parser (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .in_byte(in_tdata),
    .q_room, .res_valid, .res
  );

  umbfr_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_en(res_valid && in_tvalid && in_tready), .wr_data(res), .room(q_room),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(q_out)
  );

  // Pack result fields, first field lowest.
  assign out_tuser = q_out.kind;
  assign out_tdata = {6'd0, q_out.frame_bytes, q_out.crc_ok, q_out.crc_received,
                      q_out.body_length, q_out.cmd_id, q_out.from_class, q_out.from_id,
                      q_out.to_class, q_out.to_id, q_out.prot_version, q_out.payload_byte};

endmodule
